>>> hw/rtl/pta_pkg.sv
// Shared types and constants of the pressure-to-altitude block.
package pta_pkg;

  localparam int PRESS_W = 24;
  localparam int ALT_W = 24;
  localparam int LOG_ITERS = 32;
  localparam int LOG_W = 37;
  localparam int SERIES_TERMS = 17;
  localparam int LOG_LAT = LOG_ITERS + 1;
  localparam int EXP_LAT = 2 * SERIES_TERMS + 1;
  localparam int BACK_LAT = LOG_LAT + 3 + EXP_LAT + 3;

  localparam logic [29:0] EXP_COEF = 30'd817332276;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int ALT_SCALE = 44330;
  localparam logic [PRESS_W-1:0] SEA_RESET = 24'd6484800;
  localparam logic [ALT_W-1:0] ALT_POS_MAX = 24'h7fffff;
  localparam logic [ALT_W-1:0] ALT_NEG_MIN = 24'h800000;
  localparam logic REG_SEA_LEVEL = 1'b0;

  typedef enum logic [1:0] {
    KIND_NORMAL,
    KIND_ZERO,
    KIND_NOREF
  } kind_e;

  typedef struct packed {
    logic [PRESS_W-1:0] pressure;
    kind_e              kind;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } mid_t;

  typedef struct packed {
    logic [ALT_W-1:0] altitude;
    logic             saturated;
    logic             no_pressure;
  } result_t;

endpackage

>>> hw/rtl/pressure_to_altitude.sv
// Barometric altitude from raw pressure: top level.
// Throughput: one item per cycle unless a result waits on a full result queue,
// set by the fully pipelined log2/exp2 datapath (74 back-end stages).
// Reset: asynchronous, active low; queues empty, reference at 101325 Pa.
module pressure_to_altitude import pta_pkg::*; #(
  parameter int ALT_FRAC_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [PRESS_W-1:0] raw_pressure_i,
  output logic               empty,
  input  logic               pop,
  output logic [ALT_W-1:0]   altitude_o,
  output logic               saturated_o,
  output logic               no_pressure_o
);
  mid_t               head;
  logic               head_pop;
  logic [PRESS_W-1:0] sea;
  logic               res_valid, res_full;
  result_t            res, out;

  pta_front u_front (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .full, .raw_pressure_i,
    .head_o     (head),
    .head_pop_i (head_pop),
    .sea_o      (sea)
  );

  pta_back #(.ALT_FRAC_BITS(ALT_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .head_i      (head),
    .head_pop_o  (head_pop),
    .sea_i       (sea),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  pta_fifo #(.W($bits(result_t)), .DEPTH(2)) u_out (
    .clk_i, .rst_ni,
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out),
    .empty_o (empty)
  );

  assign altitude_o    = out.altitude;
  assign saturated_o   = out.saturated;
  assign no_pressure_o = out.no_pressure;

endmodule

>>> hw/rtl/pta_fifo.sv
// Small register queue with registered status.
module pta_fifo #(
  parameter int W = 26,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output logic         empty_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/pta_front.sv
// Front end: config register, input acceptance, classification and the item queue.
module pta_front import pta_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [PRESS_W-1:0] raw_pressure_i,
  output mid_t               head_o,
  input  logic               head_pop_i,
  output logic [PRESS_W-1:0] sea_o
);
  logic [PRESS_W-1:0] sea_q;
  item_t              item_d;
  item_t              head_item;
  logic               head_empty;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEA_LEVEL) ? {8'd0, sea_q} : '0;
  assign sea_o  = sea_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sea_q <= SEA_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEA_LEVEL)) begin
      sea_q <= pwdata[PRESS_W-1:0];
    end
  end

  always_comb begin
    item_d.pressure = raw_pressure_i;
    if (raw_pressure_i == '0) begin
      item_d.kind = KIND_ZERO;
    end else if (sea_q == '0) begin
      item_d.kind = KIND_NOREF;
    end else begin
      item_d.kind = KIND_NORMAL;
    end
  end

  pta_fifo #(.W($bits(item_t)), .DEPTH(2)) u_mid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (item_d),
    .full_o  (full),
    .pop_i   (head_pop_i),
    .data_o  (head_item),
    .empty_o (head_empty)
  );

  assign head_o.valid = !head_empty;
  assign head_o.item  = head_item;

endmodule

>>> hw/rtl/pta_log2.sv
// Pipelined log2 in Q32: normalize, then one mantissa squaring per stage.
module pta_log2 import pta_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [PRESS_W-1:0] v_i,
  output logic [LOG_W-1:0]   lg_o
);
  logic [31:0] m_q   [LOG_ITERS+1];
  logic [31:0] fr_q  [LOG_ITERS+1];
  logic [4:0]  msb_q [LOG_ITERS+1];
  logic [4:0]  msb;
  logic [31:0] m0;

  always_comb begin
    msb = '0;
    for (int i = 0; i < PRESS_W; i++) begin
      if (v_i[i]) msb = 5'(i);
    end
    m0 = {8'd0, v_i} << (5'd31 - msb);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q[0]   <= m0;
      fr_q[0]  <= '0;
      msb_q[0] <= msb;
    end
  end

  for (genvar i = 0; i < LOG_ITERS; i++) begin : g_sq
    logic [64:0] sq;
    logic [33:0] mm;
    logic [31:0] fr_d;
    always_comb begin
      sq = 65'(m_q[i]) * 65'(m_q[i]) + (65'd1 << 30);
      mm = sq[64:31];
      fr_d = fr_q[i];
      fr_d[31-i] = mm[32];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i+1]   <= mm[32] ? mm[32:1] : mm[31:0];
        fr_q[i+1]  <= fr_d;
        msb_q[i+1] <= msb_q[i];
      end
    end
  end

  assign lg_o = {msb_q[LOG_ITERS], fr_q[LOG_ITERS]};

endmodule

>>> hw/rtl/pta_exp2.sv
// Pipelined 2^f for f in [0,1) by a truncated power series; two stages per term.
module pta_exp2 import pta_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] f_i,
  output logic [33:0] x_o
);
  localparam int T = SERIES_TERMS;

  logic [31:0] yb_q    [T];
  logic [32:0] termb_q [T];
  logic [33:0] sumb_q  [T+1];
  logic [31:0] ya_q    [T];
  logic [31:0] ta_q    [T];
  logic [33:0] suma_q  [T];
  logic [64:0] fy;

  assign fy = 65'(f_i) * 65'(LN2_Q32) + (65'd1 << 31);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yb_q[0]    <= fy[63:32];
      termb_q[0] <= 33'h1_0000_0000;
      sumb_q[0]  <= 34'h1_0000_0000;
    end
  end

  for (genvar k = 1; k <= T; k++) begin : g_term
    localparam int K = k;
    localparam int L = $clog2(K);
    localparam logic [65:0] MG = ((66'd1 << (32 + L)) + 66'(K) - 66'd1) / 66'(K);
    logic [64:0] prod_a;
    logic [65:0] prod_b;
    logic [31:0] qv;

    assign prod_a = 65'(termb_q[k-1]) * 65'(yb_q[k-1]);
    assign prod_b = 66'(ta_q[k-1]) * MG;
    assign qv     = 32'(prod_b >> (32 + L));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ta_q[k-1]   <= prod_a[63:32];
        ya_q[k-1]   <= yb_q[k-1];
        suma_q[k-1] <= sumb_q[k-1];
        sumb_q[k]   <= suma_q[k-1] + 34'(qv);
      end
    end

    if (k < T) begin : g_fwd
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          termb_q[k] <= {1'b0, qv};
          yb_q[k]    <= ya_q[k-1];
        end
      end
    end
  end

  assign x_o = sumb_q[T];

endmodule

>>> hw/rtl/pta_back.sv
// Back end: log2 of both pressures, exponent, exp2, scaling and saturation.
module pta_back import pta_pkg::*; #(
  parameter int ALT_FRAC_BITS = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mid_t               head_i,
  output logic               head_pop_o,
  input  logic [PRESS_W-1:0] sea_i,
  output logic               res_valid_o,
  output result_t            res_o,
  input  logic               res_full_i
);
  localparam int SW = 16 + ALT_FRAC_BITS;
  localparam int QW = SW + 8;
  localparam int PRW = 38 + SW + 1;
  localparam logic [SW-1:0] SCALE = SW'(ALT_SCALE) << ALT_FRAC_BITS;

  logic                en;
  logic [BACK_LAT-1:0] vld_q;
  kind_e               kind_q [BACK_LAT];
  logic [LOG_W-1:0]    lp, l0;
  logic                lneg_q, lneg2_q;
  logic [LOG_W-1:0]    lmag_q;
  logic [35:0]         emag_q;
  logic [62:0]         fracc;
  logic [35:0]         ep;
  logic [3:0]          nd_q [EXP_LAT+1];
  logic [31:0]         f_q;
  logic [33:0]         sum;
  logic [37:0]         xe, x_d, x_q;
  logic [3:0]          ni, sh_s;
  logic                aneg_q, aneg2_q;
  logic [37:0]         mag_q;
  logic [PRW-1:0]      prod;
  logic [QW-1:0]       q_q;

  assign en         = !vld_q[BACK_LAT-1] || !res_full_i;
  assign head_pop_o = en && head_i.valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[BACK_LAT-2:0], head_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      kind_q[0] <= head_i.item.kind;
      for (int i = 1; i < BACK_LAT; i++) begin
        kind_q[i] <= kind_q[i-1];
      end
    end
  end

  pta_log2 u_lp (.clk_i(clk_i), .en_i(en), .v_i(head_i.item.pressure), .lg_o(lp));
  pta_log2 u_l0 (.clk_i(clk_i), .en_i(en), .v_i(sea_i), .lg_o(l0));

  assign fracc = 63'(lmag_q[31:0]) * 63'(EXP_COEF) + (63'd1 << 31);
  assign ep = lneg2_q ? ((36'd8 << 32) - emag_q) : ((36'd8 << 32) + emag_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      lneg_q  <= (lp < l0);
      lmag_q  <= (lp < l0) ? (l0 - lp) : (lp - l0);
      lneg2_q <= lneg_q;
      emag_q  <= 36'(36'(lmag_q[36:32]) * 36'(EXP_COEF)) + 36'(fracc[62:32]);
      nd_q[0] <= ep[35:32];
      f_q     <= ep[31:0];
      for (int j = 1; j <= EXP_LAT; j++) begin
        nd_q[j] <= nd_q[j-1];
      end
    end
  end

  pta_exp2 u_exp (.clk_i(clk_i), .en_i(en), .f_i(f_q), .x_o(sum));

  assign ni = nd_q[EXP_LAT];
  assign xe = {4'd0, sum};

  always_comb begin
    sh_s = 4'd8 - ni;
    if (ni >= 4'd8) begin
      x_d = xe << (ni - 4'd8);
    end else begin
      x_d = (xe + (38'd1 << (sh_s - 4'd1))) >> sh_s;
    end
  end

  assign prod = PRW'(mag_q) * PRW'(SCALE) + (PRW'(1) << 31);

  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q     <= x_d;
      aneg_q  <= (x_q > 38'h1_0000_0000);
      mag_q   <= (x_q > 38'h1_0000_0000) ? (x_q - 38'h1_0000_0000) : (38'h1_0000_0000 - x_q);
      aneg2_q <= aneg_q;
      q_q     <= QW'(prod >> 32);
    end
  end

  assign res_valid_o = vld_q[BACK_LAT-1];

  always_comb begin
    res_o.no_pressure = 1'b0;
    res_o.saturated   = 1'b0;
    res_o.altitude    = '0;
    case (kind_q[BACK_LAT-1])
      KIND_ZERO: begin
        res_o.no_pressure = 1'b1;
      end
      KIND_NOREF: begin
        res_o.altitude  = ALT_NEG_MIN;
        res_o.saturated = 1'b1;
      end
      default: begin
        if (aneg2_q) begin
          if (q_q > QW'(ALT_NEG_MIN)) begin
            res_o.altitude  = ALT_NEG_MIN;
            res_o.saturated = 1'b1;
          end else begin
            res_o.altitude = ALT_W'(0) - q_q[ALT_W-1:0];
          end
        end else begin
          if (q_q > QW'(ALT_POS_MAX)) begin
            res_o.altitude  = ALT_POS_MAX;
            res_o.saturated = 1'b1;
          end else begin
            res_o.altitude = q_q[ALT_W-1:0];
          end
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/pta_checker.sv
// Port-level assertions for the altitude block and their binding.
module pta_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [23:0] altitude_o,
  input logic        saturated_o,
  input logic        no_pressure_o
);

  a_rst_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result queue not empty in reset");

  a_zero_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && no_pressure_o) |-> (altitude_o == 24'd0 && !saturated_o))
    else $error("zero-pressure item with nonzero altitude or saturation");

  a_sat_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && saturated_o) |-> (altitude_o == 24'h800000 || altitude_o == 24'h7fffff))
    else $error("saturated item not at a range end");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(altitude_o)))
    else $error("waiting item changed or vanished");

endmodule

bind pressure_to_altitude pta_checker u_pta_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .altitude_o    (altitude_o),
  .saturated_o   (saturated_o),
  .no_pressure_o (no_pressure_o)
);
